// ===== rtl/window_function_apply_assert.svh =====
// Assertion macros used by the window function sequencer (wfa_ctrl).
// Each macro expands to a labeled concurrent assertion in simulation and to nothing in synthesis.
`ifndef WINDOW_FUNCTION_APPLY_ASSERT_SVH
`define WINDOW_FUNCTION_APPLY_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define WFA_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("window_function_apply: assertion failed");

// Next-cycle implication, checked outside reset.
`define WFA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("window_function_apply: assertion failed");

`else

`define WFA_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define WFA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== rtl/wfa_pkg.sv =====
package wfa_pkg;

    // Data path sizes.
    localparam int SAMPLE_BITS     = 24;
    localparam int MAX_FRAME       = 65536;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int PHASE_W         = 24;
    localparam int POS_W           = $clog2(MAX_FRAME);
    localparam int LEN_W           = 17;
    localparam int CMP_W           = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
    localparam int COEF_W          = 32;
    localparam int MUL_W           = 32;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int ACC_W           = 64;
    localparam int WIN_W           = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;
    localparam int HARM_W          = 3;
    localparam int STEP_W          = 3;

    // The harmonic loop runs two steps past the last harmonic to drain the pipeline.
    localparam int NUM_HARM = 4;
    localparam logic [STEP_W-1:0] HARM_LAST_STEP = STEP_W'(NUM_HARM + 1);

    // Fixed-point constants.
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint          PI_Q30     = 64'sd3373259426;
    localparam longint          ONE_Q30    = 64'sd1073741824;
    localparam logic signed [MUL_W-1:0] FLAT_NORM_Q28 = 32'sd1245424395;

    typedef enum logic [1:0] {
        WIN_RECT    = 2'd0,
        WIN_FLATTOP = 2'd1,
        WIN_HANN    = 2'd2,
        WIN_HAMMING = 2'd3
    } win_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_KIND  = 3'd0,
        CFG_NORMALIZE    = 3'd1,
        CFG_FRAME_LENGTH = 3'd2,
        CFG_PHASE_STEP   = 3'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_HARM = 2'd0,
        MUL_NORM = 2'd1,
        MUL_RE   = 2'd2,
        MUL_IM   = 2'd3
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HARM,
        ST_NORM_RND,
        ST_NORM_MUL,
        ST_WIN,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_DONE
    } wfa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              rom_rd;
        logic [HARM_W-1:0] rom_harm;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic [HARM_W-1:0] mul_harm;
        logic              acc_en;
        logic [HARM_W-1:0] acc_harm;
        logic              w30_en;
        logic              win_en;
        logic              re_en;
        logic              out_load;
    } wfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flat_norm;
    } wfa_status_t;

    typedef logic signed [COEF_W-1:0] cos_tab_t [COS_TABLE_DEPTH];

    // Cosine of a Q30 angle by a thirteen-term Taylor series, clamped to +-1.
    function automatic longint cos_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = 64'(ONE_Q30);
        sum  = ONE_Q30;
        for (int n = 1; n <= 12; n++) begin
            term = (term * x2) / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        if (sum < -ONE_Q30)
            sum = -ONE_Q30;
        return sum;
    endfunction

    // Full-turn cosine table in Q30, folded onto the first quadrant.
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t        tab;
        longint unsigned kk;
        longint          x;
        for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
            kk = 64'(k);
            if (2 * kk > 64'(COS_TABLE_DEPTH))
                kk = 64'(COS_TABLE_DEPTH) - kk;
            x = longint'((TWO_PI_Q30 * kk) / 64'(COS_TABLE_DEPTH));
            if (4 * kk > 64'(COS_TABLE_DEPTH)) begin
                x = PI_Q30 - x;
                if (x < 0)
                    x = 0;
                tab[k] = COEF_W'(-cos_q30(64'(x)));
            end
            else begin
                tab[k] = COEF_W'(cos_q30(64'(x)));
            end
        end
        return tab;
    endfunction

    // Q30 weight of harmonic m for the given window.
    function automatic logic signed [COEF_W-1:0] win_coef(win_kind_t kind, logic norm,
                                                          logic [HARM_W-1:0] m);
        logic signed [COEF_W-1:0] c0, c1, c2, c3, c4;
        logic signed [COEF_W-1:0] res;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        c4 = '0;
        unique case (kind)
            WIN_RECT: begin
                c0 = 32'sd1073741824;
            end
            WIN_FLATTOP: begin
                c0 = 32'sd231476135;
                c1 = 32'sd447354753;
                c2 = 32'sd297709050;
                c3 = 32'sd89742211;
                c4 = 32'sd7459680;
            end
            WIN_HANN: begin
                c0 = norm ? 32'sd1073741824 : 32'sd536870912;
                c1 = norm ? 32'sd1073741824 : 32'sd536870912;
            end
            WIN_HAMMING: begin
                c0 = norm ? 32'sd1073741824 : 32'sd583555339;
                c1 = norm ? 32'sd901943132 : 32'sd490186485;
            end
        endcase
        case (m)
            3'd0:    res = c0;
            3'd1:    res = c1;
            3'd2:    res = c2;
            3'd3:    res = c3;
            3'd4:    res = c4;
            default: res = '0;
        endcase
        return res;
    endfunction

    // Round to nearest with ties up, then drop sh fraction bits.
    function automatic logic signed [ACC_W-1:0] round_shift(logic signed [ACC_W-1:0] v,
                                                            int unsigned sh);
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // Saturate to a signed range of the given width.
    function automatic logic signed [ACC_W-1:0] clamp(logic signed [ACC_W-1:0] v,
                                                      int unsigned bits);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (bits - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

endpackage

// ===== rtl/wfa_ctrl.sv =====
`include "window_function_apply_assert.svh"

module wfa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  wfa_pkg::wfa_status_t  status,
    output wfa_pkg::wfa_cmd_t     cmd
);

    wfa_pkg::wfa_state_t               state_reg, state_next;
    logic [wfa_pkg::STEP_W-1:0]        step_reg, step_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_free;

    // The result slot can take a word when it is empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != wfa_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and harmonic step.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            wfa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wfa_pkg::ST_HARM;
                    step_next  = '0;
                end
            end
            wfa_pkg::ST_HARM:
            begin
                if (step_reg == wfa_pkg::HARM_LAST_STEP)
                begin
                    state_next = status.flat_norm ? wfa_pkg::ST_NORM_RND : wfa_pkg::ST_WIN;
                end
                else
                begin
                    step_next = step_reg + wfa_pkg::STEP_W'(1);
                end
            end
            wfa_pkg::ST_NORM_RND: state_next = wfa_pkg::ST_NORM_MUL;
            wfa_pkg::ST_NORM_MUL: state_next = wfa_pkg::ST_WIN;
            wfa_pkg::ST_WIN:      state_next = wfa_pkg::ST_MUL_RE;
            wfa_pkg::ST_MUL_RE:   state_next = wfa_pkg::ST_MUL_IM;
            wfa_pkg::ST_MUL_IM:   state_next = wfa_pkg::ST_DONE;
            wfa_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = wfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands. In the harmonic loop the ROM read, the multiply and the
    // accumulate work on three successive harmonics in the same cycle.
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = wfa_pkg::MUL_HARM;
        unique case (state_reg)
            wfa_pkg::ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            wfa_pkg::ST_HARM:
            begin
                cmd.rom_rd   = (step_reg < wfa_pkg::STEP_W'(wfa_pkg::NUM_HARM));
                cmd.rom_harm = wfa_pkg::HARM_W'(step_reg + wfa_pkg::STEP_W'(1));
                cmd.mul_en   = (step_reg >= wfa_pkg::STEP_W'(1))
                            && (step_reg <= wfa_pkg::STEP_W'(wfa_pkg::NUM_HARM));
                cmd.mul_harm = wfa_pkg::HARM_W'(step_reg);
                cmd.acc_en   = (step_reg >= wfa_pkg::STEP_W'(2));
                cmd.acc_harm = wfa_pkg::HARM_W'(step_reg - wfa_pkg::STEP_W'(1));
            end
            wfa_pkg::ST_NORM_RND:
            begin
                cmd.w30_en = 1'b1;
            end
            wfa_pkg::ST_NORM_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wfa_pkg::MUL_NORM;
            end
            wfa_pkg::ST_WIN:
            begin
                cmd.win_en = 1'b1;
            end
            wfa_pkg::ST_MUL_RE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wfa_pkg::MUL_RE;
            end
            wfa_pkg::ST_MUL_IM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wfa_pkg::MUL_IM;
                cmd.re_en   = 1'b1;
            end
            wfa_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
            end
        endcase
    end

    // Result slot occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfa_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `WFA_ASSERT_IMPLY(a_load_only_free, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall)
    `WFA_ASSERT_NEXT(a_accept_starts_loop, clk, rst_n, in_valid && !in_stall, state_reg == wfa_pkg::ST_HARM && step_reg == '0)
    `WFA_ASSERT_IMPLY(a_step_in_range, clk, rst_n, state_reg == wfa_pkg::ST_HARM, step_reg <= wfa_pkg::HARM_LAST_STEP)
    `WFA_ASSERT_NEXT(a_done_fills_slot, clk, rst_n, state_reg == wfa_pkg::ST_DONE && !out_valid_reg, out_valid_reg && state_reg == wfa_pkg::ST_IDLE)

endmodule

// ===== rtl/wfa_datapath.sv =====
module wfa_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  wfa_pkg::wfa_cmd_t                      cmd,
    input  wfa_pkg::win_kind_t                     kind,
    input  logic                                   normalize,
    input  logic [wfa_pkg::LEN_W-1:0]              frame_length,
    input  logic [wfa_pkg::PHASE_W-1:0]            phase_step,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0] sample_re,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0] sample_im,
    output wfa_pkg::wfa_status_t                   status,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0] windowed_re,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0] windowed_im,
    output logic signed [wfa_pkg::WIN_W-1:0]       window_value,
    output logic                                   frame_end
);

    localparam wfa_pkg::cos_tab_t COS_ROM = wfa_pkg::build_cos_tab();

    // Frame position state.
    logic [wfa_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [wfa_pkg::PHASE_W-1:0] phase_reg, phase_next;

    // Working registers for one item.
    logic signed [wfa_pkg::SAMPLE_BITS-1:0] sre_reg, sim_reg;
    logic                                   last_reg;
    logic signed [wfa_pkg::COEF_W-1:0]      cos_reg;
    logic signed [wfa_pkg::PROD_W-1:0]      product_reg;
    logic signed [wfa_pkg::ACC_W-1:0]       acc_reg;
    logic signed [wfa_pkg::MUL_W-1:0]       w30_reg;
    logic signed [wfa_pkg::WIN_W-1:0]       w_reg;
    logic signed [wfa_pkg::SAMPLE_BITS-1:0] re_res_reg;

    // Result registers.
    logic signed [wfa_pkg::SAMPLE_BITS-1:0] out_re_reg, out_im_reg;
    logic signed [wfa_pkg::WIN_W-1:0]       out_w_reg;
    logic                                   out_end_reg;

    logic [wfa_pkg::CMP_W-1:0]                  len_eff;
    logic [wfa_pkg::CMP_W-1:0]                  pos_plus;
    logic                                       is_last;
    logic [wfa_pkg::PHASE_W+wfa_pkg::HARM_W-1:0] harm_prod;
    logic [wfa_pkg::COS_IDX_W-1:0]              rom_idx;
    logic signed [wfa_pkg::MUL_W-1:0]           mul_a, mul_b;
    logic signed [wfa_pkg::PROD_W-1:0]          product_next;
    logic signed [wfa_pkg::ACC_W-1:0]           acc_init;
    logic signed [wfa_pkg::ACC_W-1:0]           win_full;
    logic signed [wfa_pkg::ACC_W-1:0]           samp_full;

    assign status.flat_norm = normalize && (kind == wfa_pkg::WIN_FLATTOP);

    // Effective frame length: zero counts as one, and long frames saturate.
    always_comb
    begin
        if (frame_length == '0)
            len_eff = wfa_pkg::CMP_W'(1);
        else if (wfa_pkg::CMP_W'(frame_length) > wfa_pkg::CMP_W'(wfa_pkg::MAX_FRAME))
            len_eff = wfa_pkg::CMP_W'(wfa_pkg::MAX_FRAME);
        else
            len_eff = wfa_pkg::CMP_W'(frame_length);
    end

    assign pos_plus = wfa_pkg::CMP_W'(pos_reg) + wfa_pkg::CMP_W'(1);
    assign is_last  = (pos_plus >= len_eff);

    // The harmonic phase wraps at a full turn; its top bits address the table.
    assign harm_prod = phase_reg * cmd.rom_harm;
    assign rom_idx   = harm_prod[wfa_pkg::PHASE_W-1 -: wfa_pkg::COS_IDX_W];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.mul_sel)
            wfa_pkg::MUL_HARM:
            begin
                mul_a = wfa_pkg::win_coef(kind, normalize, cmd.mul_harm);
                mul_b = cos_reg;
            end
            wfa_pkg::MUL_NORM:
            begin
                mul_a = w30_reg;
                mul_b = wfa_pkg::FLAT_NORM_Q28;
            end
            wfa_pkg::MUL_RE:
            begin
                mul_a = wfa_pkg::MUL_W'(sre_reg);
                mul_b = wfa_pkg::MUL_W'(w_reg);
            end
            wfa_pkg::MUL_IM:
            begin
                mul_a = wfa_pkg::MUL_W'(sim_reg);
                mul_b = wfa_pkg::MUL_W'(w_reg);
            end
        endcase
    end

    assign product_next = mul_a * mul_b;

    // The constant term starts the sum, scaled to Q60.
    assign acc_init = wfa_pkg::ACC_W'(wfa_pkg::win_coef(kind, normalize, '0)) <<< 30;

    // Window coefficient to Q16, from the Q60 sum or from the normalized product.
    always_comb
    begin
        if (status.flat_norm)
            win_full = wfa_pkg::clamp(wfa_pkg::round_shift(product_reg, 42), wfa_pkg::WIN_W);
        else
            win_full = wfa_pkg::clamp(wfa_pkg::round_shift(acc_reg, 44), wfa_pkg::WIN_W);
    end

    assign samp_full = wfa_pkg::clamp(wfa_pkg::round_shift(product_reg, 16),
                                      wfa_pkg::SAMPLE_BITS);

    // Position and phase advance once the result is handed over.
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (cmd.out_load)
        begin
            if (last_reg)
            begin
                pos_next   = '0;
                phase_next = '0;
            end
            else
            begin
                pos_next   = wfa_pkg::POS_W'(pos_plus);
                phase_next = phase_reg + phase_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sre_reg  <= sample_re;
            sim_reg  <= sample_im;
            last_reg <= is_last;
            acc_reg  <= acc_init;
        end
        else if (cmd.acc_en)
        begin
            if (cmd.acc_harm[0])
                acc_reg <= acc_reg - product_reg;
            else
                acc_reg <= acc_reg + product_reg;
        end
        if (cmd.rom_rd)
            cos_reg <= COS_ROM[rom_idx];
        if (cmd.mul_en)
            product_reg <= product_next;
        if (cmd.w30_en)
            w30_reg <= wfa_pkg::MUL_W'(wfa_pkg::round_shift(acc_reg, 30));
        if (cmd.win_en)
            w_reg <= win_full[wfa_pkg::WIN_W-1:0];
        if (cmd.re_en)
            re_res_reg <= samp_full[wfa_pkg::SAMPLE_BITS-1:0];
        if (cmd.out_load)
        begin
            out_re_reg  <= re_res_reg;
            out_im_reg  <= samp_full[wfa_pkg::SAMPLE_BITS-1:0];
            out_w_reg   <= w_reg;
            out_end_reg <= last_reg;
        end
    end

    assign windowed_re  = out_re_reg;
    assign windowed_im  = out_im_reg;
    assign window_value = out_w_reg;
    assign frame_end    = out_end_reg;

endmodule

// ===== rtl/window_function_apply.sv =====
// Flow: an accepted sample word passes the harmonic loop, the normalization states
// (normalized flat-top window only), then the window and the real and imaginary multiply
// states before its result word is loaded. No new sample word is taken until then, set by the
// single shared multiplier and the four-harmonic loop behind the registered cosine ROM.
// Reset: asynchronous, active low; clears the sequencer, result valid, frame position
// and phase, and loads the register defaults. No clearing pass is needed.
module window_function_apply (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0]    sample_re,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0]    sample_im,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0]    windowed_re,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0]    windowed_im,
    output logic signed [wfa_pkg::WIN_W-1:0]          window_value,
    output logic                                      frame_end,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]            cfg_data
);

    wfa_pkg::win_kind_t              kind_reg;
    logic                            normalize_reg;
    logic [wfa_pkg::LEN_W-1:0]       frame_length_reg;
    logic [wfa_pkg::PHASE_W-1:0]     phase_step_reg;

    wfa_pkg::wfa_cmd_t               cmd;
    wfa_pkg::wfa_status_t            status;

    assign cfg_ready = 1'b1;

    // Configuration registers; indexes outside the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= wfa_pkg::WIN_RECT;
            normalize_reg    <= 1'b0;
            frame_length_reg <= wfa_pkg::LEN_W'(1024);
            phase_step_reg   <= wfa_pkg::PHASE_W'(16384);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wfa_pkg::CFG_WINDOW_KIND:  kind_reg         <= wfa_pkg::win_kind_t'(cfg_data[1:0]);
                wfa_pkg::CFG_NORMALIZE:    normalize_reg    <= cfg_data[0];
                wfa_pkg::CFG_FRAME_LENGTH: frame_length_reg <= cfg_data[wfa_pkg::LEN_W-1:0];
                wfa_pkg::CFG_PHASE_STEP:   phase_step_reg   <= cfg_data[wfa_pkg::PHASE_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Sequencer.
    wfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Window and scaling datapath.
    wfa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind_reg),
        .normalize    (normalize_reg),
        .frame_length (frame_length_reg),
        .phase_step   (phase_step_reg),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .status       (status),
        .windowed_re  (windowed_re),
        .windowed_im  (windowed_im),
        .window_value (window_value),
        .frame_end    (frame_end)
    );

endmodule

// ===== tb/sv/tb_window_function_apply.sv =====
`timescale 1ns / 100ps

module tb_window_function_apply;
    import wfa_pkg::*;

    // Fixed-point constants of the window arithmetic.
    localparam longint          UNIT_Q30      = 64'sd1073741824;
    localparam longint unsigned TURN_Q30      = 64'd6746518852;
    localparam longint          HALF_TURN_Q30 = 64'sd3373259426;
    localparam longint          FLAT_GAIN_Q28 = 64'sd1245424395;
    localparam longint          WIN_HI        = 64'sd524287;
    localparam longint          WIN_LO        = -64'sd524288;
    localparam longint          SMP_HI        = 64'sd8388607;
    localparam longint          SMP_LO        = -64'sd8388608;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;

    // Register index that decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 1650;
    localparam int QUIET_PHASE  = 5;
    localparam int IDLE_PCT     = 37;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } sample_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic signed [WIN_W-1:0]       win;
        logic                          last;
    } windowed_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_re = '0;
    logic signed [SAMPLE_BITS-1:0] sample_im = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] windowed_re;
    logic signed [SAMPLE_BITS-1:0] windowed_im;
    logic signed [WIN_W-1:0]       window_value;
    logic                          frame_end;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    // Predictor copy of the registers and the frame state.
    win_kind_t       cur_kind;
    logic            cur_norm;
    logic [16:0]     cur_len;
    logic [23:0]     cur_step;
    int unsigned     cur_pos;
    logic [23:0]     cur_phase;
    longint          cos_lut [COS_TABLE_DEPTH];

    sample_t         sample_q [$];
    windowed_t       windowed_q [$];
    logic            in_taken = 1'b0;
    int              idle_pct = IDLE_PCT;
    int              errors = 0;
    int              quiet_cycles = 0;

    window_function_apply uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .windowed_re  (windowed_re),
        .windowed_im  (windowed_im),
        .window_value (window_value),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Thirteen-term Taylor cosine of a first-quadrant Q30 angle, clamped to +-1.
    function automatic longint taylor_cosine(longint unsigned ang);
        longint unsigned sq;
        longint unsigned part;
        longint          total;
        sq    = (ang * ang) >> 30;
        part  = 64'(UNIT_Q30);
        total = UNIT_Q30;
        for (int n = 1; n <= 12; n++)
        begin
            part = (part * sq) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                total -= longint'(part);
            else
                total += longint'(part);
        end
        if (total > UNIT_Q30)
            total = UNIT_Q30;
        else if (total < -UNIT_Q30)
            total = -UNIT_Q30;
        return total;
    endfunction

    // Q30 weight of harmonic m for a window kind.
    function automatic longint harmonic_weight(win_kind_t kind, logic nrm, int m);
        longint a [5];
        a = '{0, 0, 0, 0, 0};
        case (kind)
            WIN_RECT:
                a[0] = UNIT_Q30;
            WIN_FLATTOP:
                a = '{231476135, 447354753, 297709050, 89742211, 7459680};
            WIN_HANN:
            begin
                a[0] = nrm ? UNIT_Q30 : 64'sd536870912;
                a[1] = nrm ? UNIT_Q30 : 64'sd536870912;
            end
            WIN_HAMMING:
            begin
                a[0] = nrm ? UNIT_Q30 : 64'sd583555339;
                a[1] = nrm ? 64'sd901943132 : 64'sd490186485;
            end
            default: ;
        endcase
        return a[m];
    endfunction

    // Q16 window coefficient at the current phase.
    function automatic longint window_q16();
        longint          acc;
        longint          term;
        longint          w30;
        longint          w;
        longint unsigned ph;
        acc = harmonic_weight(cur_kind, cur_norm, 0) * UNIT_Q30;
        for (int m = 1; m <= 4; m++)
        begin
            ph   = (64'(cur_phase) * 64'(m)) & 64'hFFFFFF;
            term = harmonic_weight(cur_kind, cur_norm, m)
                   * cos_lut[(ph * 64'(COS_TABLE_DEPTH)) >> 24];
            if (m % 2 == 1)
                acc -= term;
            else
                acc += term;
        end
        if (cur_norm && cur_kind == WIN_FLATTOP)
        begin
            w30 = (acc + (64'sd1 <<< 29)) >>> 30;
            w   = (w30 * FLAT_GAIN_Q28 + (64'sd1 <<< 41)) >>> 42;
        end
        else
        begin
            w = (acc + (64'sd1 <<< 43)) >>> 44;
        end
        if (w > WIN_HI)
            w = WIN_HI;
        else if (w < WIN_LO)
            w = WIN_LO;
        return w;
    endfunction

    // One part of the sample times the window, rounded half up and saturated.
    function automatic logic signed [SAMPLE_BITS-1:0] scale_part(
        logic signed [SAMPLE_BITS-1:0] s, longint w);
        longint r;
        r = (longint'(s) * w + 64'sd32768) >>> 16;
        if (r > SMP_HI)
            r = SMP_HI;
        else if (r < SMP_LO)
            r = SMP_LO;
        return SAMPLE_BITS'(r);
    endfunction

    // Expected result word for one sample; advances the frame position and phase.
    function automatic windowed_t window_sample(sample_t s);
        int unsigned len;
        longint      w;
        windowed_t   r;
        len = cur_len;
        if (len == 0)
            len = 1;
        if (len > MAX_FRAME)
            len = MAX_FRAME;
        w      = window_q16();
        r.re   = scale_part(s.re, w);
        r.im   = scale_part(s.im, w);
        r.win  = WIN_W'(w);
        r.last = (cur_pos + 1 >= len);
        if (r.last)
        begin
            cur_pos   = 0;
            cur_phase = '0;
        end
        else
        begin
            cur_pos   = cur_pos + 1;
            cur_phase = cur_phase + cur_step;
        end
        return r;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Sample driver: holds a word until it is taken, idles at random, stalls the output at random.
    always @(negedge clk)
    begin : sample_driver
        sample_t s;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < idle_pct);
            if (!in_valid || in_taken)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    s = sample_q.pop_front();
                    sample_re <= s.re;
                    sample_im <= s.im;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: tracks register writes, predicts each taken sample, checks results.
    always @(posedge clk)
    begin : result_monitor
        sample_t   s;
        windowed_t want;
        if (!rst_n)
        begin
            in_taken = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WINDOW_KIND:  cur_kind = win_kind_t'(cfg_data[1:0]);
                    CFG_NORMALIZE:    cur_norm = cfg_data[0];
                    CFG_FRAME_LENGTH: cur_len = cfg_data[16:0];
                    CFG_PHASE_STEP:   cur_step = cfg_data;
                    default: ;
                endcase
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                s.re = sample_re;
                s.im = sample_im;
                windowed_q.push_back(window_sample(s));
            end
            if (out_valid && !out_stall)
            begin
                if (windowed_q.size() == 0)
                begin
                    flag_error("result word with no sample outstanding");
                end
                else
                begin
                    want = windowed_q.pop_front();
                    if (windowed_re !== want.re)
                        flag_error($sformatf("windowed_re: expected %0d, got %0d",
                                             want.re, windowed_re));
                    if (windowed_im !== want.im)
                        flag_error($sformatf("windowed_im: expected %0d, got %0d",
                                             want.im, windowed_im));
                    if (window_value !== want.win)
                        flag_error($sformatf("window_value: expected %0d, got %0d",
                                             want.win, window_value));
                    if (frame_end !== want.last)
                        flag_error($sformatf("frame_end: expected %0b, got %0b",
                                             want.last, frame_end));
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_window_function_apply: FAIL");
            $finish;
        end
    end

    // Register write; bits the register ignores carry random values.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        logic [CFG_DATA_W-1:0] keep;
        case (idx)
            CFG_WINDOW_KIND:  keep = 24'h000003;
            CFG_NORMALIZE:    keep = 24'h000001;
            CFG_FRAME_LENGTH: keep = 24'h01FFFF;
            CFG_PHASE_STEP:   keep = 24'hFFFFFF;
            default:          keep = 24'h000000;
        endcase
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(logic signed [SAMPLE_BITS-1:0] re,
                                logic signed [SAMPLE_BITS-1:0] im);
        sample_t s;
        s.re = re;
        s.im = im;
        sample_q.push_back(s);
    endtask

    // Sender holds off until every word sent has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || in_valid || windowed_q.size() != 0);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Stimulus: directed corners first, then random phases over all window settings.
    initial
    begin : stimulus
        int unsigned fold;
        longint      ang;
        int          phase_no;
        int          sent;
        int          count;
        int unsigned len_pick;
        int unsigned len_eff;
        int unsigned step_pick;

        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            fold = (2 * k > COS_TABLE_DEPTH) ? COS_TABLE_DEPTH - k : k;
            ang  = longint'((TURN_Q30 * 64'(fold)) / 64'(COS_TABLE_DEPTH));
            if (4 * fold > COS_TABLE_DEPTH)
            begin
                ang = HALF_TURN_Q30 - ang;
                if (ang < 0)
                    ang = 0;
                cos_lut[k] = -taylor_cosine(64'(ang));
            end
            else
            begin
                cos_lut[k] = taylor_cosine(64'(ang));
            end
        end

        cur_kind  = WIN_RECT;
        cur_norm  = 1'b0;
        cur_len   = 17'd1024;
        cur_step  = 24'd16384;
        cur_pos   = 0;
        cur_phase = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: rectangular window passes extreme samples unchanged.
        queue_sample(SMP_MAX, SMP_MIN);
        queue_sample(SMP_MIN, SMP_MAX);
        queue_sample('0, '0);
        queue_sample(-24'sd1, 24'sd1);
        queue_sample(SMP_MAX, SMP_MAX);
        queue_sample(SMP_MIN, SMP_MIN);
        wait_idle();

        // Frame length lowered below the current position ends the frame at once.
        write_reg(CFG_FRAME_LENGTH, 3);
        queue_sample(SMP_MAX, SMP_MIN);
        queue_sample(24'sd12345, -24'sd12345);
        wait_idle();

        // Normalized flat-top peaks above one, so extreme samples saturate.
        write_reg(CFG_WINDOW_KIND, WIN_FLATTOP);
        write_reg(CFG_NORMALIZE, 1);
        write_reg(CFG_FRAME_LENGTH, 4);
        write_reg(CFG_PHASE_STEP, 24'h400000);
        for (int i = 0; i < 4; i++)
        begin
            queue_sample(SMP_MAX, SMP_MIN);
            queue_sample(SMP_MIN, SMP_MAX);
        end
        wait_idle();

        // Zero frame length acts as one; a write to an unused index is dropped.
        write_reg(CFG_FRAME_LENGTH, 0);
        write_reg(CFG_SPARE, 0);
        queue_sample(SMP_MAX, 24'sd1);
        queue_sample(-24'sd1, SMP_MIN);
        wait_idle();

        // Frame length past the maximum saturates; full-scale phase step.
        write_reg(CFG_WINDOW_KIND, WIN_HAMMING);
        write_reg(CFG_NORMALIZE, 0);
        write_reg(CFG_FRAME_LENGTH, 17'h1FFFF);
        write_reg(CFG_PHASE_STEP, 24'hFFFFFF);
        queue_sample(SMP_MAX, SMP_MIN);
        queue_sample(SMP_MIN, SMP_MAX);
        queue_sample(24'sd1, -24'sd1);
        wait_idle();

        // Random phases; the window kind and normalization cycle through all settings.
        phase_no = 0;
        sent     = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_pct = (phase_no == QUIET_PHASE) ? 0 : IDLE_PCT;
            write_reg(CFG_WINDOW_KIND, phase_no % 4);
            write_reg(CFG_NORMALIZE, (phase_no / 4) % 2);
            if (phase_no < 2 || $urandom_range(3) != 0)
            begin
                case ($urandom_range(9))
                    0:       len_pick = 0;
                    1:       len_pick = 1;
                    2:       len_pick = MAX_FRAME;
                    3:       len_pick = $urandom_range(17'h1FFFF, MAX_FRAME + 1);
                    4:       len_pick = $urandom_range(17'h1FFFF);
                    default: len_pick = $urandom_range(64, 2);
                endcase
                write_reg(CFG_FRAME_LENGTH, len_pick);
            end
            len_eff = cur_len;
            if (len_eff == 0)
                len_eff = 1;
            if (len_eff > MAX_FRAME)
                len_eff = MAX_FRAME;
            case ($urandom_range(7))
                0:       step_pick = 0;
                1:       step_pick = 24'hFFFFFF;
                2:       step_pick = $urandom_range(24'hFFFFFF);
                default: step_pick = ((1 << 24) + len_eff / 2) / len_eff;
            endcase
            write_reg(CFG_PHASE_STEP, step_pick);

            count = (phase_no == QUIET_PHASE) ? 200 : $urandom_range(96, 16);
            for (int i = 0; i < count; i++)
                queue_sample(random_sample(), random_sample());
            sent += count;
            wait_idle();
            phase_no++;
        end

        idle_pct = IDLE_PCT;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (windowed_q.size() != 0)
            flag_error($sformatf("%0d result words never arrived", windowed_q.size()));
        if (errors == 0)
            $display("tb_window_function_apply: PASS");
        else
            $display("tb_window_function_apply: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wfa_pkg.sv
rtl/wfa_ctrl.sv
rtl/wfa_datapath.sv
rtl/window_function_apply.sv
tb/sv/tb_window_function_apply.sv
